/* hdl/vcd_pkg.sv */
// Shared types, constants and helpers for the vertex cluster decimator.
`default_nettype none
package vcd_pkg;

    localparam int MAX_VERTS       = 256;
    localparam int MAX_EDGES       = 384;
    localparam int VERT_HASH_DEPTH = 512;
    localparam int EDGE_HASH_DEPTH = 512;
    localparam int MAX_GRID        = 64;

    localparam int VH_AW  = $clog2(VERT_HASH_DEPTH);
    localparam int EH_AW  = $clog2(EDGE_HASH_DEPTH);
    localparam int VI_W   = $clog2(MAX_VERTS);
    localparam int VC_W   = VI_W + 1;
    localparam int EC_W   = $clog2(MAX_EDGES + 1);
    localparam int CELL_W = $clog2(MAX_GRID);
    localparam int GRID_W = CELL_W + 1;
    localparam int KEY_W  = 3 * CELL_W;

    localparam logic [31:0] MIX_C1 = 32'h7feb352d;
    localparam logic [31:0] MIX_C2 = 32'h846ca68b;

    localparam logic OP_TRIANGLE = 1'b0;
    localparam logic OP_CLEAR    = 1'b1;

    typedef enum logic [2:0] {
        KIND_VERTEX  = 3'd0,
        KIND_EDGE    = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_OVERFLOW = 3'd3,
        KIND_BBOX_MIN = 3'd4,
        KIND_BBOX_MAX = 3'd5,
        KIND_CLEARED = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        CFG_BUILD_MODE = 3'd0,
        CFG_ORIGIN_X   = 3'd1,
        CFG_ORIGIN_Y   = 3'd2,
        CFG_ORIGIN_Z   = 3'd3,
        CFG_CELL_SIZE  = 3'd4,
        CFG_GRID_CELLS = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CLR_EMIT, S_OVF, S_BB_UPD, S_BB_MIN, S_BB_MAX,
        S_QSTART, S_QWAIT, S_MIX1, S_MIX2, S_MIX3, S_HRD, S_HCHK, S_SRD,
        S_SCHK, S_VEMIT, S_ENEXT, S_EEMIT, S_DONE
    } t_state;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [31:0]        index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [7:0]         edge_low;
        logic [7:0]         edge_high;
        logic               last;
    } t_out;

    // Pick one coordinate of one corner: c selects a, b, c; ax selects x, y, z.
    function automatic logic signed [31:0] corner(input t_in t, input logic [1:0] c,
                                                  input logic [1:0] ax);
        logic signed [31:0] v;
        case ({c, ax})
            4'b0000: v = t.a_x;
            4'b0001: v = t.a_y;
            4'b0010: v = t.a_z;
            4'b0100: v = t.b_x;
            4'b0101: v = t.b_y;
            4'b0110: v = t.b_z;
            4'b1000: v = t.c_x;
            4'b1001: v = t.c_y;
            4'b1010: v = t.c_z;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hdl/vertex_cluster_decimator_top.sv */
// Top level of the vertex cluster decimator: control, hash memories and records.
// Clear item: a sweep of all 512 entries of both hash memories, one entry of each per cycle.
// Build item: per corner 3 quantiser passes (one restoring division bit per cycle),
//   hash mixing through S_MIX1, S_MIX2 and S_MIX3, then probes of S_HRD and S_HCHK,
//   with S_SRD and S_SCHK on an occupied slot; per edge the same mixing and probes.
// One item at a time; the next transfer is taken once the last record is loaded.
// Reset: control and configuration registers return to their reset values and a clearing
//   sweep of all 512 entries runs with input ready held low; configuration writes are taken throughout.
`default_nettype none
module vertex_cluster_decimator_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire vcd_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output vcd_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    localparam int VH_AW  = vcd_pkg::VH_AW;
    localparam int EH_AW  = vcd_pkg::EH_AW;
    localparam int VI_W   = vcd_pkg::VI_W;
    localparam int VC_W   = vcd_pkg::VC_W;
    localparam int EC_W   = vcd_pkg::EC_W;
    localparam int KEY_W  = vcd_pkg::KEY_W;
    localparam int GRID_W = vcd_pkg::GRID_W;
    localparam int CELL_W = vcd_pkg::CELL_W;
    localparam int CLR_W  = (VH_AW > EH_AW) ? VH_AW : EH_AW;
    localparam int SIDX_W = (VC_W > EC_W) ? VC_W : EC_W;

    // configuration registers
    logic               r_build_mode;
    logic signed [31:0] r_origin [0:2];
    logic [30:0]        r_cell_size;
    logic [6:0]         r_grid_cells;
    logic [GRID_W-1:0]  g_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build_mode <= 1'b0;
            r_origin[0]  <= '0;
            r_origin[1]  <= '0;
            r_origin[2]  <= '0;
            r_cell_size  <= '0;
            r_grid_cells <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vcd_pkg::CFG_BUILD_MODE: r_build_mode <= i_cfg_data[0];
                vcd_pkg::CFG_ORIGIN_X:   r_origin[0]  <= i_cfg_data;
                vcd_pkg::CFG_ORIGIN_Y:   r_origin[1]  <= i_cfg_data;
                vcd_pkg::CFG_ORIGIN_Z:   r_origin[2]  <= i_cfg_data;
                vcd_pkg::CFG_CELL_SIZE:  r_cell_size  <= i_cfg_data[30:0];
                vcd_pkg::CFG_GRID_CELLS: r_grid_cells <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // zero grid acts as one cell, oversize grid clamps to the maximum
    always_comb begin
        if (r_grid_cells == 7'd0)
            g_eff = GRID_W'(1);
        else if (32'(r_grid_cells) > vcd_pkg::MAX_GRID)
            g_eff = GRID_W'(vcd_pkg::MAX_GRID);
        else
            g_eff = GRID_W'(r_grid_cells);
    end

    // control and datapath registers
    vcd_pkg::t_state   r_state, n_state;
    vcd_pkg::t_in      r_tri;
    logic [CLR_W-1:0]  r_clr_cnt;
    logic              r_clr_emit;
    logic signed [31:0] r_bb_min [0:2];
    logic signed [31:0] r_bb_max [0:2];
    logic              r_bb_valid;
    logic [31:0]       r_tcount;
    logic              r_ovf;
    logic [VC_W-1:0]   r_vcnt;
    logic [EC_W-1:0]   r_ecnt;
    logic [1:0]        r_ci;
    logic [1:0]        r_ei;
    logic [1:0]        r_axis;
    logic [KEY_W-1:0]  r_key;
    logic [31:0]       r_x;
    logic [31:0]       r_m;
    logic [CLR_W-1:0]  r_h;
    logic [CLR_W:0]    r_step;
    logic              r_is_edge;
    logic [SIDX_W-1:0] r_sidx;
    logic [VI_W-1:0]   r_vi [0:2];
    logic [7:0]        r_l, r_u;
    logic [EC_W-1:0]   r_eidx;
    logic              r_o_valid;
    vcd_pkg::t_out     r_out;

    // memories and their ports
    logic [VC_W-1:0]  vhash [0:vcd_pkg::VERT_HASH_DEPTH-1];
    logic [EC_W-1:0]  ehash [0:vcd_pkg::EDGE_HASH_DEPTH-1];
    logic [KEY_W-1:0] vkey  [0:vcd_pkg::MAX_VERTS-1];
    logic [15:0]      estore [0:vcd_pkg::MAX_EDGES-1];
    logic [VC_W-1:0]  vh_rd;
    logic [EC_W-1:0]  eh_rd;
    logic [KEY_W-1:0] vk_rd;
    logic [15:0]      es_rd;

    // combinational control
    logic              in_fire, out_free, emit, q_start, q_done;
    logic [CELL_W-1:0] q_cell;
    logic              hash_we_v, hash_we_e, clr_we;
    logic              new_entry, probe_adv, set_ovf, hit, next_corner, next_edge;
    logic              edge_go, bb_step;
    vcd_pkg::t_out     n_out;
    logic [1:0]        ei_next;
    logic [VI_W-1:0]   va, vb;
    logic [KEY_W-1:0]  key_next;
    logic [SIDX_W-1:0] entry;
    logic              entry_zero, entry_ok, pool_full, store_match, last_step;
    logic signed [31:0] cur [0:2];

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_o_valid || i_out_ready;
    assign ei_next  = (r_ei == 2'd2) ? 2'd0 : r_ei + 2'd1;
    assign va       = r_vi[r_ei];
    assign vb       = r_vi[ei_next];
    assign key_next = KEY_W'(r_key * KEY_W'(g_eff)) + KEY_W'(q_cell);
    assign entry    = r_is_edge ? SIDX_W'(eh_rd) : SIDX_W'(vh_rd);
    assign entry_zero = (entry == '0);
    assign entry_ok = r_is_edge ? (32'(entry) <= vcd_pkg::MAX_EDGES)
                                : (32'(entry) <= vcd_pkg::MAX_VERTS);
    assign pool_full = r_is_edge ? (32'(r_ecnt) >= vcd_pkg::MAX_EDGES)
                                 : (32'(r_vcnt) >= vcd_pkg::MAX_VERTS);
    assign store_match = r_is_edge ? (es_rd == {r_l, r_u}) : (vk_rd == r_key);
    assign last_step = r_is_edge ? (32'(r_step) == vcd_pkg::EDGE_HASH_DEPTH - 1)
                                 : (32'(r_step) == vcd_pkg::VERT_HASH_DEPTH - 1);

    always_comb begin
        for (int a = 0; a < 3; a++) cur[a] = vcd_pkg::corner(r_tri, r_ci, 2'(a));
    end

    vcd_quant u_quant (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (q_start),
        .i_coord     (vcd_pkg::corner(r_tri, r_ci, 2'd2 - r_axis)),
        .i_origin    (r_origin[2'd2 - r_axis]),
        .i_cell_size (r_cell_size),
        .i_grid      (g_eff),
        .o_done      (q_done),
        .o_cell      (q_cell)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= vcd_pkg::S_CLEAR;
        else          r_state <= n_state;
    end

    // next state, record assembly and action strobes
    always_comb begin
        n_state     = r_state;
        emit        = 1'b0;
        n_out       = '0;
        q_start     = 1'b0;
        clr_we      = 1'b0;
        hash_we_v   = 1'b0;
        hash_we_e   = 1'b0;
        new_entry   = 1'b0;
        probe_adv   = 1'b0;
        set_ovf     = 1'b0;
        hit         = 1'b0;
        next_corner = 1'b0;
        next_edge   = 1'b0;
        edge_go     = 1'b0;
        bb_step     = 1'b0;
        o_in_ready  = 1'b0;
        case (r_state)
            vcd_pkg::S_CLEAR: begin
                clr_we = 1'b1;
                if (r_clr_cnt == '1)
                    n_state = r_clr_emit ? vcd_pkg::S_CLR_EMIT : vcd_pkg::S_IDLE;
            end
            vcd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_fire) begin
                    if (i_in_data.opcode == vcd_pkg::OP_CLEAR) n_state = vcd_pkg::S_CLEAR;
                    else if (r_ovf)                            n_state = vcd_pkg::S_OVF;
                    else if (r_build_mode)                     n_state = vcd_pkg::S_QSTART;
                    else                                       n_state = vcd_pkg::S_BB_UPD;
                end
            end
            vcd_pkg::S_CLR_EMIT: begin
                n_out.kind = vcd_pkg::KIND_CLEARED;
                n_out.last = 1'b1;
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = vcd_pkg::S_IDLE;
                end
            end
            vcd_pkg::S_OVF: begin
                n_out.kind  = vcd_pkg::KIND_OVERFLOW;
                n_out.index = r_tcount;
                n_out.last  = 1'b1;
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = vcd_pkg::S_IDLE;
                end
            end
            vcd_pkg::S_BB_UPD: begin
                bb_step = 1'b1;
                if (r_ci == 2'd2) n_state = vcd_pkg::S_BB_MIN;
            end
            vcd_pkg::S_BB_MIN: begin
                n_out.kind    = vcd_pkg::KIND_BBOX_MIN;
                n_out.index   = r_tcount;
                n_out.coord_x = r_bb_min[0];
                n_out.coord_y = r_bb_min[1];
                n_out.coord_z = r_bb_min[2];
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = vcd_pkg::S_BB_MAX;
                end
            end
            vcd_pkg::S_BB_MAX: begin
                n_out.kind    = vcd_pkg::KIND_BBOX_MAX;
                n_out.index   = r_tcount;
                n_out.coord_x = r_bb_max[0];
                n_out.coord_y = r_bb_max[1];
                n_out.coord_z = r_bb_max[2];
                n_out.last    = 1'b1;
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = vcd_pkg::S_IDLE;
                end
            end
            vcd_pkg::S_QSTART: begin
                q_start = 1'b1;
                n_state = vcd_pkg::S_QWAIT;
            end
            vcd_pkg::S_QWAIT: begin
                if (q_done) n_state = (r_axis == 2'd2) ? vcd_pkg::S_MIX1 : vcd_pkg::S_QSTART;
            end
            vcd_pkg::S_MIX1: n_state = vcd_pkg::S_MIX2;
            vcd_pkg::S_MIX2: n_state = vcd_pkg::S_MIX3;
            vcd_pkg::S_MIX3: n_state = vcd_pkg::S_HRD;
            vcd_pkg::S_HRD:  n_state = vcd_pkg::S_HCHK;
            vcd_pkg::S_HCHK: begin
                if (entry_zero) begin
                    if (pool_full) begin
                        set_ovf = 1'b1;
                        n_state = vcd_pkg::S_OVF;
                    end else begin
                        new_entry = 1'b1;
                        hash_we_v = !r_is_edge;
                        hash_we_e = r_is_edge;
                        n_state   = r_is_edge ? vcd_pkg::S_EEMIT : vcd_pkg::S_VEMIT;
                    end
                end else if (entry_ok) begin
                    n_state = vcd_pkg::S_SRD;
                end else if (last_step) begin
                    set_ovf = 1'b1;
                    n_state = vcd_pkg::S_OVF;
                end else begin
                    probe_adv = 1'b1;
                    n_state   = vcd_pkg::S_HRD;
                end
            end
            vcd_pkg::S_SRD: n_state = vcd_pkg::S_SCHK;
            vcd_pkg::S_SCHK: begin
                if (store_match) begin
                    if (r_is_edge) begin
                        next_edge = 1'b1;
                        n_state   = (r_ei == 2'd2) ? vcd_pkg::S_DONE : vcd_pkg::S_ENEXT;
                    end else begin
                        hit         = 1'b1;
                        next_corner = 1'b1;
                        n_state     = (r_ci == 2'd2) ? vcd_pkg::S_ENEXT : vcd_pkg::S_QSTART;
                    end
                end else if (last_step) begin
                    set_ovf = 1'b1;
                    n_state = vcd_pkg::S_OVF;
                end else begin
                    probe_adv = 1'b1;
                    n_state   = vcd_pkg::S_HRD;
                end
            end
            vcd_pkg::S_VEMIT: begin
                n_out.kind    = vcd_pkg::KIND_VERTEX;
                n_out.index   = 32'(r_vi[r_ci]);
                n_out.coord_x = cur[0];
                n_out.coord_y = cur[1];
                n_out.coord_z = cur[2];
                if (out_free) begin
                    emit        = 1'b1;
                    next_corner = 1'b1;
                    n_state     = (r_ci == 2'd2) ? vcd_pkg::S_ENEXT : vcd_pkg::S_QSTART;
                end
            end
            vcd_pkg::S_ENEXT: begin
                if (va == vb) begin
                    next_edge = 1'b1;
                    n_state   = (r_ei == 2'd2) ? vcd_pkg::S_DONE : vcd_pkg::S_ENEXT;
                end else begin
                    edge_go = 1'b1;
                    n_state = vcd_pkg::S_MIX1;
                end
            end
            vcd_pkg::S_EEMIT: begin
                n_out.kind      = vcd_pkg::KIND_EDGE;
                n_out.index     = 32'(r_eidx);
                n_out.edge_low  = r_l;
                n_out.edge_high = r_u;
                if (out_free) begin
                    emit      = 1'b1;
                    next_edge = 1'b1;
                    n_state   = (r_ei == 2'd2) ? vcd_pkg::S_DONE : vcd_pkg::S_ENEXT;
                end
            end
            vcd_pkg::S_DONE: begin
                n_out.kind  = vcd_pkg::KIND_DONE;
                n_out.index = r_tcount;
                n_out.last  = 1'b1;
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = vcd_pkg::S_IDLE;
                end
            end
            default: n_state = vcd_pkg::S_IDLE;
        endcase
    end

    // control state: counts, flags, bounding box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_emit <= 1'b0;
            r_bb_valid <= 1'b0;
            r_tcount   <= '0;
            r_ovf      <= 1'b0;
            r_vcnt     <= '0;
            r_ecnt     <= '0;
            r_ci       <= '0;
            r_ei       <= '0;
            r_axis     <= '0;
            for (int a = 0; a < 3; a++) begin
                r_bb_min[a] <= '0;
                r_bb_max[a] <= '0;
            end
        end else begin
            if (r_state == vcd_pkg::S_CLEAR) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (in_fire) begin
                if (i_in_data.opcode == vcd_pkg::OP_CLEAR) begin
                    // drop counts, box and sticky overflow, then sweep both hashes
                    r_clr_cnt  <= '0;
                    r_clr_emit <= 1'b1;
                    r_bb_valid <= 1'b0;
                    r_tcount   <= '0;
                    r_ovf      <= 1'b0;
                    r_vcnt     <= '0;
                    r_ecnt     <= '0;
                    for (int a = 0; a < 3; a++) begin
                        r_bb_min[a] <= '0;
                        r_bb_max[a] <= '0;
                    end
                end else if (!r_ovf) begin
                    r_tcount <= r_tcount + 32'd1;
                    r_ci     <= '0;
                    r_ei     <= '0;
                    r_axis   <= '0;
                end
            end
            if (bb_step) begin
                for (int a = 0; a < 3; a++) begin
                    if (!r_bb_valid || cur[a] < r_bb_min[a]) r_bb_min[a] <= cur[a];
                    if (!r_bb_valid || cur[a] > r_bb_max[a]) r_bb_max[a] <= cur[a];
                end
                r_bb_valid <= 1'b1;
                r_ci       <= r_ci + 2'd1;
            end
            if (r_state == vcd_pkg::S_QWAIT && q_done) r_axis <= r_axis + 2'd1;
            if (new_entry) begin
                if (r_is_edge) r_ecnt <= r_ecnt + 1'b1;
                else           r_vcnt <= r_vcnt + 1'b1;
            end
            if (next_corner) begin
                r_ci   <= r_ci + 2'd1;
                r_axis <= '0;
            end
            if (next_edge) r_ei <= r_ei + 2'd1;
            if (set_ovf) r_ovf <= 1'b1;
        end
    end

    // payload of the walk: key, mixer, probe pointer, vertex indices
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tri     <= i_in_data;
            r_key     <= '0;
            r_is_edge <= 1'b0;
        end
        if (r_state == vcd_pkg::S_QWAIT && q_done) begin
            r_key <= key_next;
            r_x   <= 32'(key_next);
        end
        if (next_corner) r_key <= '0;
        if (r_state == vcd_pkg::S_MIX1) r_m <= (r_x ^ (r_x >> 16)) * vcd_pkg::MIX_C1;
        if (r_state == vcd_pkg::S_MIX2) r_m <= (r_m ^ (r_m >> 15)) * vcd_pkg::MIX_C2;
        if (r_state == vcd_pkg::S_MIX3) begin
            r_h    <= CLR_W'(r_m ^ (r_m >> 16));
            r_step <= '0;
        end
        if (r_state == vcd_pkg::S_HCHK && !entry_zero) r_sidx <= entry - 1'b1;
        if (probe_adv) begin
            r_h    <= r_h + 1'b1;
            r_step <= r_step + 1'b1;
        end
        if (new_entry) begin
            if (r_is_edge) r_eidx      <= r_ecnt;
            else           r_vi[r_ci]  <= r_vcnt[VI_W-1:0];
        end
        if (hit) r_vi[r_ci] <= r_sidx[VI_W-1:0];
        if (edge_go) begin
            r_l       <= 8'((va < vb) ? va : vb);
            r_u       <= 8'((va < vb) ? vb : va);
            r_x       <= {8'd0, 8'((va < vb) ? va : vb), 8'd0, 8'((va < vb) ? vb : va)};
            r_is_edge <= 1'b1;
        end
    end

    // hash memories: cleared by the sweep, else written with index+1 at the probe
    always_ff @(posedge i_clk) begin
        if (clr_we || hash_we_v)
            vhash[clr_we ? VH_AW'(r_clr_cnt) : VH_AW'(r_h)] <=
                clr_we ? '0 : r_vcnt + 1'b1;
        if (clr_we || hash_we_e)
            ehash[clr_we ? EH_AW'(r_clr_cnt) : EH_AW'(r_h)] <=
                clr_we ? '0 : r_ecnt + 1'b1;
        vh_rd <= vhash[VH_AW'(r_h)];
        eh_rd <= ehash[EH_AW'(r_h)];
    end

    // stores behind the hashes, read in the cycle after the index is set
    always_ff @(posedge i_clk) begin
        if (hash_we_v) vkey[r_vcnt[VI_W-1:0]] <= r_key;
        if (hash_we_e) estore[r_ecnt[EC_W-1:0]] <= {r_l, r_u};
        vk_rd <= vkey[r_sidx[VI_W-1:0]];
        es_rd <= estore[r_sidx[EC_W-1:0]];
    end

    // output register: hold the record until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= n_out;
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

/* hdl/vcd_quant.sv */
// Iterative cell quantiser: clamp((coord - origin) / cell_size, 0, grid-1).
`default_nettype none
module vcd_quant (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [31:0]           i_coord,
    input  wire logic signed [31:0]           i_origin,
    input  wire logic [30:0]                  i_cell_size,
    input  wire logic [vcd_pkg::GRID_W-1:0]   i_grid,
    output logic                              o_done,
    output logic [vcd_pkg::CELL_W-1:0]        o_cell
);
    logic                r_busy;
    logic                r_done;
    logic [2:0]          r_k;
    logic [31:0]         r_rem;
    logic [7:0]          r_q;
    logic                r_zero;
    logic signed [32:0]  diff;
    logic [38:0]         trial;
    logic                ge;
    logic [vcd_pkg::GRID_W-1:0] gm1;

    assign diff  = 33'(i_coord) - 33'(i_origin);
    assign trial = {8'd0, i_cell_size} << r_k;
    assign ge    = {7'd0, r_rem} >= trial;
    assign gm1   = i_grid - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // restoring division, one quotient bit a cycle, bit 7 flags saturation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k    <= 3'd7;
            r_rem  <= diff[31:0];
            r_q    <= '0;
            r_zero <= (i_cell_size == '0) || diff[32] || (diff == '0);
        end else if (r_busy) begin
            if (ge) r_rem <= r_rem - trial[31:0];
            r_q[r_k] <= ge;
            r_k      <= r_k - 3'd1;
        end
    end

    assign o_done = r_done;

    always_comb begin
        if (r_zero)
            o_cell = '0;
        else if (r_q[7] || {1'b0, r_q[6:0]} >= 8'(i_grid))
            o_cell = gm1[vcd_pkg::CELL_W-1:0];
        else
            o_cell = r_q[vcd_pkg::CELL_W-1:0];
    end
endmodule
`default_nettype wire

/* hdl/vcd_checker.sv */
// Port-level checker for the vertex cluster decimator, bound to the top level.
`default_nettype none
module vcd_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire vcd_pkg::t_out o_out_data
);
    // a stalled record holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("record changed while stalled");

    // the clearing sweep after reset keeps input closed
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready during clearing sweep");

    // last marks exactly the closing record kinds
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last ==
            (o_out_data.kind == vcd_pkg::KIND_DONE ||
             o_out_data.kind == vcd_pkg::KIND_OVERFLOW ||
             o_out_data.kind == vcd_pkg::KIND_BBOX_MAX ||
             o_out_data.kind == vcd_pkg::KIND_CLEARED)))
        else $error("last flag does not match record kind");

    // an added edge joins two distinct vertices in order
    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == vcd_pkg::KIND_EDGE |->
            o_out_data.edge_low < o_out_data.edge_high)
        else $error("edge ends out of order");
endmodule

bind vertex_cluster_decimator_top vcd_checker u_vcd_checker (.*);
`default_nettype wire
